FILE: hw/rtl/hiseq_pkg.sv
// ----------------------------------------------------------------------------
// hiseq_pkg
// shared constants and types for the histogram equalizer
// ----------------------------------------------------------------------------
package hiseq_pkg;

    localparam int MAX_PIXELS_LOG2 = 20;
    localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
    localparam int PIX_W           = 8;
    localparam int NUM_BINS        = 1 << PIX_W;
    localparam int PROD_W          = CNT_W + PIX_W;
    localparam int STEP_W          = 3;
    localparam int QUO_STEPS       = 1 << STEP_W;

    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(1) << MAX_PIXELS_LOG2;
    localparam logic [PIX_W-1:0] LAST_BIN = PIX_W'(NUM_BINS - 1);

    typedef struct packed {
        logic busy;
        logic done;
    } hiseq_div_stat_t;

endpackage

FILE: hw/rtl/histogram_equalizer_core.sv
// ----------------------------------------------------------------------------
// histogram_equalizer_core
// two-pass 8-bit grayscale histogram equalization
// ----------------------------------------------------------------------------
// input beats carry operation, pixel and last; output beats carry pixel_out
// and last_out. an accumulate beat (operation 0) adds the pixel to its bin
// and produces no output; pixels past 2^20 are dropped. an accumulate beat
// with last set starts the table build. a map beat (operation 1) returns
// one output beat holding the table value; with last set it also clears
// the histogram and pixel count.
// input beats are taken one at a time, set by the read-modify-write of the
// single-port bin memory and the table memory read. a map beat passes M_RD,
// then M_PUT, where it loads the output register and raises m_valid.
// the table build walks the 256 bins, each through bin read, running sum,
// then 8 steps of the shared divider and write-back, while s_ready is low.
// reset clears the histogram and count through per-bin valid flags and
// makes the table read as zero until the first build; no clearing pass.
// a stalled receiver holds the output register; accumulate beats still go in,
// the next map beat is accepted and then s_ready stays low until it drains.
// ----------------------------------------------------------------------------
module histogram_equalizer_core
    import hiseq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_operation,
    input  logic [PIX_W-1:0] s_pixel,
    input  logic             s_last,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_pixel_out,
    output logic             m_last_out
);

    typedef enum logic [3:0] {
        IDLE, A_RD, A_WR, B_RD, B_ACC, B_START, B_WAIT, M_RD, M_PUT
    } state_t;

    state_t              state_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    pixel_total_reg;
    logic [NUM_BINS-1:0] hist_vld_reg;
    logic                table_built_reg;
    logic [PIX_W-1:0]    bin_idx_reg;
    logic [CNT_W-1:0]    cum_reg;
    logic                m_valid_reg;
    logic [PIX_W-1:0]    m_pixel_out_reg;
    logic                m_last_out_reg;

    logic [CNT_W-1:0]    hist_mem [NUM_BINS];
    logic [PIX_W-1:0]    table_mem [NUM_BINS];
    logic [CNT_W-1:0]    hist_rdata_reg;
    logic                hist_rvld_reg;
    logic [PIX_W-1:0]    table_rdata_reg;

    logic [PIX_W-1:0]    hist_addr;
    logic [CNT_W-1:0]    bin_value;
    logic                s_fire;
    logic                out_free;
    logic                out_load;
    logic                div_start;
    logic [PROD_W-1:0]   product;
    hiseq_div_stat_t     div_stat;
    logic [PIX_W-1:0]    div_quot;
    logic                tbl_write;

    assign s_ready   = (state_reg == IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == M_PUT) && out_free;
    assign hist_addr = (state_reg == A_RD) ? pix_reg : bin_idx_reg;
    assign bin_value = hist_rvld_reg ? hist_rdata_reg : '0;
    assign div_start = (state_reg == B_START);
    assign product   = {cum_reg, PIX_W'(0)} - PROD_W'(cum_reg);
    assign tbl_write = (state_reg == B_WAIT) && div_stat.done;

    hiseq_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (pixel_total_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // bin memory
    always_ff @(posedge aclk) begin
        hist_rdata_reg <= hist_mem[hist_addr];
        hist_rvld_reg  <= hist_vld_reg[hist_addr];
        if (state_reg == A_WR) begin
            hist_mem[pix_reg] <= bin_value + 1'b1;
        end
    end

    // mapping table memory
    always_ff @(posedge aclk) begin
        table_rdata_reg <= table_mem[pix_reg];
        if (tbl_write) begin
            table_mem[bin_idx_reg] <= (pixel_total_reg == '0) ? '0 : div_quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= IDLE;
            pixel_total_reg <= '0;
            hist_vld_reg    <= '0;
            table_built_reg <= 1'b0;
            bin_idx_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_fire) begin
                        pix_reg  <= s_pixel;
                        last_reg <= s_last;
                        if (s_operation) begin
                            state_reg <= M_RD;
                            if (s_last) begin
                                hist_vld_reg    <= '0;
                                pixel_total_reg <= '0;
                            end
                        end else if (pixel_total_reg < CAPACITY) begin
                            state_reg <= A_RD;
                        end else if (s_last) begin
                            state_reg   <= B_RD;
                            bin_idx_reg <= '0;
                            cum_reg     <= '0;
                        end
                    end
                end
                A_RD: begin
                    state_reg <= A_WR;
                end
                A_WR: begin
                    hist_vld_reg[pix_reg] <= 1'b1;
                    pixel_total_reg       <= pixel_total_reg + 1'b1;
                    if (last_reg) begin
                        state_reg   <= B_RD;
                        bin_idx_reg <= '0;
                        cum_reg     <= '0;
                    end else begin
                        state_reg <= IDLE;
                    end
                end
                B_RD: begin
                    state_reg <= B_ACC;
                end
                B_ACC: begin
                    cum_reg   <= cum_reg + bin_value;
                    state_reg <= B_START;
                end
                B_START: begin
                    state_reg <= B_WAIT;
                end
                B_WAIT: begin
                    if (div_stat.done) begin
                        bin_idx_reg <= bin_idx_reg + 1'b1;
                        if (bin_idx_reg == LAST_BIN) begin
                            table_built_reg <= 1'b1;
                            state_reg       <= IDLE;
                        end else begin
                            state_reg <= B_RD;
                        end
                    end
                end
                M_RD: begin
                    state_reg <= M_PUT;
                end
                M_PUT: begin
                    if (out_load) begin
                        m_pixel_out_reg <= table_built_reg ? table_rdata_reg : '0;
                        m_last_out_reg  <= last_reg;
                        state_reg       <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_out_reg;
    assign m_last_out  = m_last_out_reg;

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == B_WAIT))
        else $error("divider result outside wait state");

    a_build_sets_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (tbl_write && bin_idx_reg == LAST_BIN) |=> table_built_reg)
        else $error("table not marked built after last bin");

    a_map_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_operation && s_last) |=> (pixel_total_reg == '0))
        else $error("pixel count not cleared by final map beat");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == A_WR) |=>
            (pixel_total_reg == CNT_W'($past(pixel_total_reg) + 1'b1)))
        else $error("pixel count did not advance by one");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");
`endif

endmodule

FILE: hw/rtl/hiseq_divider.sv
// ----------------------------------------------------------------------------
// hiseq_divider
// restoring divider, one compare and subtract per cycle, 8-bit quotient
// ----------------------------------------------------------------------------
module hiseq_divider
    import hiseq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [PROD_W-1:0]      dividend,
    input  logic [CNT_W-1:0]       divisor,
    output hiseq_div_stat_t        stat,
    output logic [PIX_W-1:0]       quotient
);

    logic [PROD_W-1:0] rem_reg;
    logic [PIX_W-1:0]  quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [PROD_W-1:0] shifted;

    assign shifted = PROD_W'(divisor) << step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= dividend;
                quot_reg <= '0;
                step_reg <= STEP_W'(QUO_STEPS - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (rem_reg >= shifted) begin
                    rem_reg            <= rem_reg - shifted;
                    quot_reg[step_reg] <= 1'b1;
                end
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule
